>>> hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared codes and constants for the LFU store with LRU tiebreak.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] CNT_MAX    = '1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } fsm_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_INSERT
  } upd_kind_t;

endpackage

>>> hdl/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// One table entry plus one stage of the scan chain.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int IDX      = 0,
  parameter int IW       = 4,
  parameter int OW       = 5,
  parameter int TW       = 8,
  parameter int UW       = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [TW-1:0] tok_in,
  output logic [TW-1:0] tok_out,
  input  logic [UW-1:0] upd_in
);
  import lfu_pkg::*;

  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] key;
    logic              hit;
    logic [IW-1:0]     hit_idx;
    logic [DATA_W-1:0] hit_val;
    logic [IW-1:0]     hit_rank;
    logic [OW-1:0]     occ;
    logic              free_fnd;
    logic [IW-1:0]     free_idx;
    logic              best_fnd;
    logic [IW-1:0]     best_idx;
    logic [DATA_W-1:0] best_cnt;
    logic [IW-1:0]     best_rank;
    logic [DATA_W-1:0] best_key;
  } tok_t;

  typedef struct packed {
    upd_kind_t         kind;
    logic [IW-1:0]     slot;
    logic [IW-1:0]     rank;
    logic              wr_val;
    logic              evict;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
  } upd_t;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic              valid;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] value;
  logic [DATA_W-1:0] cnt;
  logic [IW-1:0]     rank;

  tok_t ti, tn, tr;
  upd_t u;

  assign ti      = tok_t'(tok_in);
  assign u       = upd_t'(upd_in);
  assign tok_out = TW'(tr);

  // fold this entry into the passing token
  always_comb begin
    tn = ti;
    if (valid) begin
      tn.occ = ti.occ + OW'(1);
      if (key == ti.key && !ti.hit) begin
        tn.hit      = 1'b1;
        tn.hit_idx  = MY_IDX;
        tn.hit_val  = value;
        tn.hit_rank = rank;
      end
      if (!ti.best_fnd || cnt < ti.best_cnt ||
          (cnt == ti.best_cnt && rank > ti.best_rank)) begin
        tn.best_fnd  = 1'b1;
        tn.best_idx  = MY_IDX;
        tn.best_cnt  = cnt;
        tn.best_rank = rank;
        tn.best_key  = key;
      end
    end else if (!ti.free_fnd) begin
      tn.free_fnd = 1'b1;
      tn.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tr.vld <= 1'b0;
    end else begin
      tr <= tn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (u.kind)
        UPD_TOUCH: begin
          if (u.slot == MY_IDX) begin
            rank <= '0;
            if (cnt != CNT_MAX) cnt <= cnt + DATA_W'(1);
            if (u.wr_val) value <= u.val;
          end else if (valid && rank < u.rank) begin
            rank <= rank + IW'(1);
          end
        end
        UPD_INSERT: begin
          if (u.slot == MY_IDX) begin
            valid <= 1'b1;
            key   <= u.key;
            value <= u.val;
            cnt   <= DATA_W'(1);
            rank  <= '0;
          end else if (valid && !(u.evict && rank > u.rank)) begin
            // younger than the evicted entry, or no eviction: age by one
            rank <= rank + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/lfu_cache_lru_tiebreak_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_unit
// Key-value store with least-frequently-used replacement, LRU tiebreak.
// ----------------------------------------------------------------------------
// Each transaction on the slave side is a get (tuser 0) or a put (tuser 1)
// and yields exactly one result transaction on the master side. Entries sit
// in a row of CAPACITY cells; a scan token walks the row one cell per cycle,
// collecting key match, occupancy, first free slot and the eviction
// candidate (lowest use count, oldest among equals). An apply step then
// broadcasts the update to all cells and loads the output register, once
// the master side is free. The scan time is set by the length of the cell
// chain, and the next transaction is taken after the apply step. One item
// is processed at a time, but a new item is accepted while the previous
// result still waits on m_tready. capacity_in_use is written through
// cfg_we/cfg_wdata; it is to be written only while idle, which the block
// itself does not enforce. Values above CAPACITY act as CAPACITY. Use
// counts saturate at all ones. No clearing pass is needed after reset.
module lfu_cache_lru_tiebreak_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [63:0]              s_tdata,   // lookup_key, write_value
  input  logic [0:0]               s_tuser,   // action
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [63:0]              m_tdata,   // read_value, evicted_key
  output logic [1:0]               m_tuser,   // hit, evicted
  input  logic                     cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata
);
  import lfu_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > CFG_W) ? OW : CFG_W;

  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] key;
    logic              hit;
    logic [IW-1:0]     hit_idx;
    logic [DATA_W-1:0] hit_val;
    logic [IW-1:0]     hit_rank;
    logic [OW-1:0]     occ;
    logic              free_fnd;
    logic [IW-1:0]     free_idx;
    logic              best_fnd;
    logic [IW-1:0]     best_idx;
    logic [DATA_W-1:0] best_cnt;
    logic [IW-1:0]     best_rank;
    logic [DATA_W-1:0] best_key;
  } tok_t;

  typedef struct packed {
    upd_kind_t         kind;
    logic [IW-1:0]     slot;
    logic [IW-1:0]     rank;
    logic              wr_val;
    logic              evict;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
  } upd_t;

  localparam int TW = $bits(tok_t);
  localparam int UW = $bits(upd_t);

  fsm_t state, state_next;

  logic [CFG_W-1:0]  cap_reg;
  logic              req_act;
  logic [DATA_W-1:0] req_val;
  tok_t              scan;
  upd_t              upd;

  logic [TW-1:0]       chain [CAPACITY+1];
  logic [CAPACITY-1:0] chain_vld;
  tok_t                inj, last_tok;

  logic s_accept, out_free, load_out;
  logic hit_o, evicted_o;
  logic [DATA_W-1:0] rd_o, ekey_o;
  logic [CW-1:0] cap_ext, cap_eff;

  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // token entering the first cell
  always_comb begin
    inj     = '0;
    inj.vld = s_accept;
    inj.key = s_tdata[DATA_W-1:0];
  end
  assign chain[0] = TW'(inj);
  assign last_tok = tok_t'(chain[CAPACITY]);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lfu_cell #(
      .IDX(g), .IW(IW), .OW(OW), .TW(TW), .UW(UW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .upd_in  (UW'(upd))
    );
    assign chain_vld[g] = chain[g+1][TW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CFG_W'(16);
    end else if (cfg_we) begin
      cap_reg <= cfg_wdata;
    end
  end

  assign cap_ext = CW'(cap_reg);
  assign cap_eff = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_act <= s_tuser[0];
      req_val <= s_tdata[2*DATA_W-1:DATA_W];
    end
    if (last_tok.vld) scan <= last_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, decision and update broadcast
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    upd        = '0;
    upd.kind   = UPD_NONE;
    upd.key    = scan.key;
    upd.val    = req_val;
    hit_o      = scan.hit;
    evicted_o  = 1'b0;
    rd_o       = '0;
    ekey_o     = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_tok.vld) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (req_act == ACT_GET) begin
            if (scan.hit) begin
              upd.kind = UPD_TOUCH;
              upd.slot = scan.hit_idx;
              upd.rank = scan.hit_rank;
              rd_o     = scan.hit_val;
            end else begin
              rd_o = MISS_VALUE;
            end
          end else if (cap_eff != '0) begin
            if (scan.hit) begin
              upd.kind   = UPD_TOUCH;
              upd.slot   = scan.hit_idx;
              upd.rank   = scan.hit_rank;
              upd.wr_val = 1'b1;
            end else if (CW'(scan.occ) >= cap_eff) begin
              upd.kind  = UPD_INSERT;
              upd.slot  = scan.best_idx;
              upd.rank  = scan.best_rank;
              upd.evict = 1'b1;
              evicted_o = 1'b1;
              ekey_o    = scan.best_key;
            end else begin
              upd.kind = UPD_INSERT;
              upd.slot = scan.free_idx;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {ekey_o, rd_o};
      m_tuser <= {evicted_o, hit_o};
    end
  end

  // at most one scan token in the chain, and only while scanning
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_vld))
    else $error("more than one scan token in flight");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (chain_vld == '0))
    else $error("scan token outside scan");

  a_scan_has_token: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> $onehot(chain_vld))
    else $error("scan state without token");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_APPLY))
    else $error("result without apply step");

endmodule
